[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LSC_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed");
`define LSC_ASSERT_NR(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("assertion failed");
`else
`define LSC_ASSERT(lbl, ck, rs, prop)
`define LSC_ASSERT_NR(lbl, ck, prop)
`endif

`endif

[rtl/core/lsc_pkg.sv]
package lsc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int WIN_MIN_RESET  = 50;
  localparam int WIN_MAX_RESET  = 150;
  localparam int CFG_IDX_BITS   = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_idx_t;

endpackage

[rtl/core/lsc_seg_if.sv]
interface lsc_seg_if
  import lsc_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

[rtl/core/lsc_clip_if.sv]
interface lsc_clip_if
  import lsc_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] clipped_start_x;
  logic signed [W-1:0] clipped_start_y;
  logic signed [W-1:0] clipped_end_x;
  logic signed [W-1:0] clipped_end_y;
  logic                visible;

  modport source (output valid, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, visible, input ready);
  modport sink (input valid, clipped_start_x, clipped_start_y, clipped_end_x,
                clipped_end_y, visible, output ready);
endinterface

[rtl/core/line_segment_window_clipper.sv]
// Liang-Barsky segment clipper against a window held in four registers
// (index 0..3: x min, x max, y min, y max). One segment is taken per cycle
// while the result is not stalled; each passes four arithmetic stages, then
// COORD_BITS stages of the bit-per-stage restoring dividers, then the output
// register. A stalled result freezes the whole pipeline. Rejected
// segments come out with visible low and all coordinates zero. Write the
// window only while the pipeline is empty.
module line_segment_window_clipper
  import lsc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  lsc_seg_if.sink                 seg,
  lsc_clip_if.source              clip
);
`include "assert_macros.svh"

  localparam int W  = COORD_BITS;
  localparam int NW = W + 2;
  localparam int PW = 2 * W + 4;

  logic signed [W-1:0] lo [2];
  logic signed [W-1:0] hi [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      lo[0] <= W'(WIN_MIN_RESET);
      hi[0] <= W'(WIN_MAX_RESET);
      lo[1] <= W'(WIN_MIN_RESET);
      hi[1] <= W'(WIN_MAX_RESET);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_X_MIN: lo[0] <= cfg_data;
        REG_X_MAX: hi[0] <= cfg_data;
        REG_Y_MIN: lo[1] <= cfg_data;
        REG_Y_MAX: hi[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_v;

  assign adv       = !out_v || clip.ready;
  assign seg.ready = adv;

  // stage 1: edge terms
  logic signed [W-1:0]  in_p0 [2];
  logic signed [W-1:0]  in_p1 [2];
  logic signed [NW-1:0] c1_d   [2];
  logic signed [NW-1:0] c1_qlo [2];
  logic signed [NW-1:0] c1_qhi [2];
  logic signed [NW-1:0] c1_ent [2];
  logic signed [NW-1:0] c1_ext [2];
  logic [W-1:0]         c1_ad  [2];
  logic [1:0]           c1_act;
  logic [1:0]           c1_par;

  assign in_p0[0] = seg.start_x;
  assign in_p0[1] = seg.start_y;
  assign in_p1[0] = seg.end_x;
  assign in_p1[1] = seg.end_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      c1_d[a]   = NW'(in_p1[a]) - NW'(in_p0[a]);
      c1_qlo[a] = NW'(in_p0[a]) - NW'(lo[a]);
      c1_qhi[a] = NW'(hi[a]) - NW'(in_p0[a]);
      c1_ad[a]  = c1_d[a] < 0 ? W'(-c1_d[a]) : W'(c1_d[a]);
      c1_ent[a] = c1_d[a] > 0 ? -c1_qlo[a] : -c1_qhi[a];
      c1_ext[a] = c1_d[a] > 0 ? c1_qhi[a] : c1_qlo[a];
      c1_act[a] = c1_d[a] != 0;
      c1_par[a] = c1_d[a] == 0 && (c1_qlo[a] < 0 || c1_qhi[a] < 0);
    end
  end

  logic                 s1_v;
  logic signed [W-1:0]  s1_p0  [2];
  logic signed [NW-1:0] s1_d   [2];
  logic [W-1:0]         s1_ad  [2];
  logic signed [NW-1:0] s1_ent [2];
  logic signed [NW-1:0] s1_ext [2];
  logic [1:0]           s1_act;
  logic                 s1_rej;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p0  <= in_p0;
      s1_d   <= c1_d;
      s1_ad  <= c1_ad;
      s1_ent <= c1_ent;
      s1_ext <= c1_ext;
      s1_act <= c1_act;
      s1_rej <= |c1_par;
    end
  end

  // stage 2: pick entry maximum and exit minimum
  logic signed [W:0]    c2_ads [2];
  logic signed [PW-1:0] c2_ent_xy, c2_ent_yx, c2_ext_xy, c2_ext_yx;
  logic                 c2_ent_sel, c2_ext_sel;
  logic signed [NW-1:0] c2_en, c2_xn;
  logic [W-1:0]         c2_ed, c2_xd;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      c2_ads[a] = {1'b0, s1_ad[a]};
    end
    c2_ent_xy = PW'(s1_ent[0]) * PW'(c2_ads[1]);
    c2_ent_yx = PW'(s1_ent[1]) * PW'(c2_ads[0]);
    c2_ext_xy = PW'(s1_ext[0]) * PW'(c2_ads[1]);
    c2_ext_yx = PW'(s1_ext[1]) * PW'(c2_ads[0]);
    case (s1_act)
      2'b11: begin
        c2_ent_sel = c2_ent_yx > c2_ent_xy;
        c2_ext_sel = c2_ext_yx < c2_ext_xy;
      end
      2'b10: begin
        c2_ent_sel = 1'b1;
        c2_ext_sel = 1'b1;
      end
      default: begin
        c2_ent_sel = 1'b0;
        c2_ext_sel = 1'b0;
      end
    endcase
    c2_en = s1_ent[c2_ent_sel];
    c2_ed = s1_ad[c2_ent_sel];
    c2_xn = s1_ext[c2_ext_sel];
    c2_xd = s1_ad[c2_ext_sel];
    if (s1_act == 2'b00 || c2_en <= 0) begin
      c2_en = NW'(0);
      c2_ed = W'(1);
    end
    if (s1_act == 2'b00 || c2_xn >= $signed({2'b00, c2_xd})) begin
      c2_xn = NW'(1);
      c2_xd = W'(1);
    end
  end

  logic                 s2_v;
  logic signed [W-1:0]  s2_p0 [2];
  logic signed [NW-1:0] s2_d  [2];
  logic signed [NW-1:0] s2_en, s2_xn;
  logic [W-1:0]         s2_ed, s2_xd;
  logic                 s2_rej;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p0  <= s1_p0;
      s2_d   <= s1_d;
      s2_en  <= c2_en;
      s2_xn  <= c2_xn;
      s2_ed  <= c2_ed;
      s2_xd  <= c2_xd;
      s2_rej <= s1_rej;
    end
  end

  // stage 3: products
  logic signed [W:0] c3_eds, c3_xds;

  assign c3_eds = {1'b0, s2_ed};
  assign c3_xds = {1'b0, s2_xd};

  logic                 s3_v;
  logic signed [PW-1:0] s3_enxd, s3_xned;
  logic signed [PW-1:0] s3_sa [2];
  logic signed [PW-1:0] s3_sb [2];
  logic signed [PW-1:0] s3_ea [2];
  logic signed [PW-1:0] s3_eb [2];
  logic [W-1:0]         s3_ed, s3_xd;
  logic                 s3_rej;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_enxd <= PW'(s2_en) * PW'(c3_xds);
      s3_xned <= PW'(s2_xn) * PW'(c3_eds);
      for (int a = 0; a < 2; a++) begin
        s3_sa[a] <= PW'(s2_p0[a]) * PW'(c3_eds);
        s3_sb[a] <= PW'(s2_en) * PW'(s2_d[a]);
        s3_ea[a] <= PW'(s2_p0[a]) * PW'(c3_xds);
        s3_eb[a] <= PW'(s2_xn) * PW'(s2_d[a]);
      end
      s3_ed  <= s2_ed;
      s3_xd  <= s2_xd;
      s3_rej <= s2_rej;
    end
  end

  // stage 4: numerators as sign and magnitude
  logic signed [PW-1:0] c4_n [4];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      c4_n[a]     = s3_sa[a] + s3_sb[a];
      c4_n[a + 2] = s3_ea[a] + s3_eb[a];
    end
  end

  logic          s4_v;
  logic [PW-1:0] s4_mag [4];
  logic [3:0]    s4_sgn;
  logic [W-1:0]  s4_ed, s4_xd;
  logic          s4_rej;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s4_mag[k] <= c4_n[k] < 0 ? PW'(-c4_n[k]) : PW'(c4_n[k]);
        s4_sgn[k] <= c4_n[k] < 0;
      end
      s4_ed  <= s3_ed;
      s4_xd  <= s3_xd;
      s4_rej <= s3_rej || (s3_enxd > s3_xned);
    end
  end

  // dividers and their sideband
  logic [W-1:0] quo [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    lsc_div #(
      .W     (W),
      .NUM_W (PW)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (s4_mag[k]),
      .den (k < 2 ? s4_ed : s4_xd),
      .quo (quo[k])
    );
  end

  logic [W-1:0] sb_v;
  logic [W-1:0] sb_rej;
  logic [3:0]   sb_sgn [W];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_rej[0] <= s4_rej;
      sb_sgn[0] <= s4_sgn;
      for (int i = 1; i < W; i++) begin
        sb_rej[i] <= sb_rej[i-1];
        sb_sgn[i] <= sb_sgn[i-1];
      end
    end
  end

  // output register
  logic signed [W-1:0] out_c [4];
  logic                out_vis;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        if (sb_rej[W-1]) begin
          out_c[k] <= '0;
        end else begin
          out_c[k] <= sb_sgn[W-1][k] ? -quo[k] : quo[k];
        end
      end
      out_vis <= !sb_rej[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      sb_v  <= '0;
      out_v <= 1'b0;
    end else if (adv) begin
      s1_v  <= seg.valid;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      s4_v  <= s3_v;
      sb_v  <= {sb_v[W-2:0], s4_v};
      out_v <= sb_v[W-1];
    end
  end

  assign clip.valid           = out_v;
  assign clip.clipped_start_x = out_c[0];
  assign clip.clipped_start_y = out_c[1];
  assign clip.clipped_end_x   = out_c[2];
  assign clip.clipped_end_y   = out_c[3];
  assign clip.visible         = out_vis;

  `LSC_ASSERT(a_reject_zero, clk, rst, clip.valid && !clip.visible |-> clip.clipped_start_x == '0 && clip.clipped_start_y == '0 && clip.clipped_end_x == '0 && clip.clipped_end_y == '0)
  `LSC_ASSERT(a_stall_freeze, clk, rst, clip.valid && !clip.ready |=> $stable(s1_v) && $stable(s4_v) && $stable(sb_v))
  `LSC_ASSERT_NR(a_reset_empty, clk, rst |=> !clip.valid && !s1_v && sb_v == '0)

endmodule

[rtl/core/lsc_div.sv]
module lsc_div
  import lsc_pkg::*;
#(
  parameter int W      = COORD_BITS_DEF,
  parameter int NUM_W  = 2 * COORD_BITS_DEF + 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [W-1:0]     den,
  output logic [W-1:0]     quo
);

  logic [NUM_W-1:0] rem_q [W];
  logic [W-1:0]     den_q [W];
  logic [W-1:0]     quo_q [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [W-1:0]     den_in;
    logic [W-1:0]     quo_in;
    logic [NUM_W-1:0] sub;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign sub = NUM_W'(den_in) << (W - 1 - i);
    assign ge  = rem_in >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? rem_in - sub : rem_in;
        den_q[i] <= den_in;
        quo_q[i] <= quo_in | (W'(ge) << (W - 1 - i));
      end
    end
  end

  assign quo = quo_q[W-1];

endmodule
